// ----- rtl/dds_pkg.sv -----
// ----------------------------------------------------------------------------
// dds_pkg
// Shared types, constants and helper functions of the delayed dual
// exponential synapse core.
// ----------------------------------------------------------------------------
package dds_pkg;

  // Default depth of the pending spike queue
  localparam int unsigned PENDING_DEPTH_DEF = 16;

  // Field widths
  localparam int unsigned DATA_W    = 16;  // voltage and register width
  localparam int unsigned CUR_W     = 32;  // current, Q16.16
  localparam int unsigned TRACE_W   = 32;  // traces, Q16.16
  localparam int unsigned CFG_IDX_W = 3;

  // Due-time stamps: wide enough that the largest delay plus the longest
  // wait behind the queue front stays below half the stamp range
  localparam int unsigned TIME_W = 18;

  // Shared multiplier: signed 34 x signed 18
  localparam int unsigned MUL_A_W = 34;
  localparam int unsigned MUL_B_W = 18;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  // Register reset values
  localparam logic [DATA_W-1:0] PEAK_RST     = 16'd6554;
  localparam logic [DATA_W-1:0] REVERSAL_RST = 16'hA600;  // -23040
  localparam logic [DATA_W-1:0] FALL_RST     = 16'd62000;
  localparam logic [DATA_W-1:0] RISE_RST     = 16'd53000;
  localparam logic [DATA_W-1:0] INV_PEAK_RST = 16'd4096;
  localparam logic [DATA_W-1:0] DELAY_RST    = 16'd0;

  // Saturation bounds of the current
  localparam logic [CUR_W-1:0] CUR_MAX = 32'h7FFF_FFFF;
  localparam logic [CUR_W-1:0] CUR_MIN = 32'h8000_0000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PEAK       = 3'd0,
    REG_REVERSAL   = 3'd1,
    REG_FALL_DECAY = 3'd2,
    REG_RISE_DECAY = 3'd3,
    REG_INV_PEAK   = 3'd4,
    REG_DELAY      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic        [DATA_W-1:0] peak_conductance;
    logic signed [DATA_W-1:0] reversal_potential;
    logic        [DATA_W-1:0] fall_decay;
    logic        [DATA_W-1:0] rise_decay;
    logic        [DATA_W-1:0] inverse_peak;
    logic        [DATA_W-1:0] delay_ticks;
  } cfg_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_APPLY,
    ST_MUL_F,
    ST_MUL_R,
    ST_DIFF,
    ST_MUL_G,
    ST_MUL_I,
    ST_DONE
  } dds_state_t;

  // Multiplier operand selection
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_FALL,
    MUL_RISE,
    MUL_COND,
    MUL_CURR
  } mul_op_t;

  // Commands from the controller
  typedef struct packed {
    logic    load_in;
    logic    prep;
    logic    apply;
    mul_op_t mul_op;
    logic    store_fall;
    logic    store_rise;
    logic    load_out;
  } cmd_t;

  // Queue status toward the datapath
  typedef struct packed {
    logic fire;
    logic full;
  } q_status_t;

  // Add the Q4.12 increment to a Q16.16 trace, saturate at all ones
  function automatic logic [TRACE_W-1:0] trace_sat_add(input logic [TRACE_W-1:0] t,
                                                       input logic [DATA_W-1:0] inc);
    logic [TRACE_W:0] s;
    s = {1'b0, t} + {13'd0, inc, 4'd0};
    return s[TRACE_W] ? {TRACE_W{1'b1}} : s[TRACE_W-1:0];
  endfunction

  // Floor-shift the product by 8 and clamp to the signed 32-bit range
  function automatic logic [CUR_W-1:0] sat_current(input logic [PROD_W-1:0] p);
    logic [12:0] hi;
    hi = p[PROD_W-1:39];
    if (hi == 13'h0000 || hi == 13'h1FFF) begin
      return p[39:8];
    end else if (p[PROD_W-1]) begin
      return CUR_MIN;
    end else begin
      return CUR_MAX;
    end
  endfunction

endpackage

// ----- rtl/dds_in_if.sv -----
// ----------------------------------------------------------------------------
// dds_in_if
// Input channel: one tick of membrane voltage and presynaptic spike flag.
// ----------------------------------------------------------------------------
interface dds_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [dds_pkg::DATA_W-1:0]  membrane_voltage;
  logic                               spike_now;

  modport source (output valid, membrane_voltage, spike_now, input ready);
  modport sink   (input valid, membrane_voltage, spike_now, output ready);
endinterface

// ----- rtl/dds_out_if.sv -----
// ----------------------------------------------------------------------------
// dds_out_if
// Result channel: synaptic current and dropped-spike flag of one tick.
// ----------------------------------------------------------------------------
interface dds_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [dds_pkg::CUR_W-1:0]  synaptic_current;
  logic                              spike_dropped;

  modport source (output valid, synaptic_current, spike_dropped, input ready);
  modport sink   (input valid, synaptic_current, spike_dropped, output ready);
endinterface

// ----- rtl/dds_ctrl.sv -----
// ----------------------------------------------------------------------------
// dds_ctrl
// Sequencer of one tick: queue read, spike apply, the four multiplies of
// the shared multiplier and the output load.
// ----------------------------------------------------------------------------
module dds_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          out_free,
  output logic          in_ready,
  output dds_pkg::cmd_t cmd
);
  import dds_pkg::*;

  dds_state_t state_r;
  dds_state_t state_nxt;
  logic       accept;

  assign accept = in_valid && (state_r == ST_IDLE);

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_MUL_F;
      ST_MUL_F: state_nxt = ST_MUL_R;
      ST_MUL_R: state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_MUL_G;
      ST_MUL_G: state_nxt = ST_MUL_I;
      ST_MUL_I: state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_READ:  cmd.prep   = 1'b1;
      ST_APPLY: cmd.apply  = 1'b1;
      ST_MUL_F: cmd.mul_op = MUL_FALL;
      ST_MUL_R: begin
        cmd.mul_op     = MUL_RISE;
        cmd.store_fall = 1'b1;
      end
      ST_DIFF:  cmd.store_rise = 1'b1;
      ST_MUL_G: cmd.mul_op     = MUL_COND;
      ST_MUL_I: cmd.mul_op     = MUL_CURR;
      ST_DONE:  cmd.load_out   = out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_starts_tick: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_READ)
    else $error("transfer did not start a tick");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !out_free) |=> state_r == ST_DONE)
    else $error("result left while output register full");
`endif

endmodule

// ----- rtl/dds_queue.sv -----
// ----------------------------------------------------------------------------
// dds_queue
// Pending spike queue. Each entry holds the tick stamp at which the spike
// falls due; the front fires once the tick counter has reached its stamp.
// ----------------------------------------------------------------------------
module dds_queue #(
  parameter int unsigned PENDING_DEPTH = dds_pkg::PENDING_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dds_pkg::cmd_t               cmd,
  input  logic                        spike_now,
  input  logic [dds_pkg::DATA_W-1:0]  delay_ticks,
  output dds_pkg::q_status_t          status
);
  import dds_pkg::*;

  localparam int unsigned IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(PENDING_DEPTH + 1);

  logic [TIME_W-1:0] mem [PENDING_DEPTH];
  logic [TIME_W-1:0] rd_r;
  logic [TIME_W-1:0] tick_r, tick_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TIME_W-1:0] stamp;
  logic [TIME_W-1:0] elapsed;
  logic              full;
  logic              enq;
  logic              deq;
  logic              fire;

  assign full    = (count_r == CNT_W'(PENDING_DEPTH));
  assign enq     = cmd.load_in && spike_now && !full;
  assign stamp   = tick_r + TIME_W'(delay_ticks);
  // Front is due when the signed distance from its stamp is not negative
  assign elapsed = tick_r - rd_r;
  assign fire    = (count_r != '0) && !elapsed[TIME_W-1];
  assign deq     = cmd.apply && fire;

  assign status.fire = fire;
  assign status.full = full;

  // Write the due stamp at the tail; the front is read through a register
  always_ff @(posedge clk) begin
    if (enq) begin
      mem[tail_r] <= stamp;
    end
    rd_r <= mem[head_r];
  end

  // Pointer, count and tick updates
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    tick_nxt  = tick_r;
    if (enq) begin
      tail_nxt  = (tail_r == IDX_W'(PENDING_DEPTH - 1)) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end
    if (deq) begin
      head_nxt  = (head_r == IDX_W'(PENDING_DEPTH - 1)) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
    if (cmd.apply) begin
      tick_nxt = tick_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      tick_r  <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      tick_r  <= tick_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(PENDING_DEPTH))
    else $error("queue count above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> head_r == tail_r)
    else $error("empty queue with split pointers");
`endif

endmodule

// ----- rtl/dds_datapath.sv -----
// ----------------------------------------------------------------------------
// dds_datapath
// Traces, shared multiplier and output register of the synapse core.
// ----------------------------------------------------------------------------
module dds_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dds_pkg::cmd_t                      cmd,
  input  dds_pkg::cfg_t                      cfg,
  input  dds_pkg::q_status_t                 q_status,
  input  logic signed [dds_pkg::DATA_W-1:0]  membrane_voltage,
  input  logic                               spike_now,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic signed [dds_pkg::CUR_W-1:0]   out_synaptic_current,
  output logic                               out_spike_dropped,
  output logic                               out_free
);
  import dds_pkg::*;

  logic        [TRACE_W-1:0]  fall_r, fall_nxt;
  logic        [TRACE_W-1:0]  rise_r, rise_nxt;
  logic signed [DATA_W-1:0]   vm_r;
  logic                       drop_r;
  logic signed [MUL_B_W-1:0]  drive_r;
  logic        [TRACE_W:0]    diff_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic                       out_valid_r, out_valid_nxt;
  logic        [CUR_W-1:0]    out_cur_r;
  logic                       out_drop_r;

  assign out_free = !out_valid_r || out_ready;

  // Latch the tick's inputs and the drive voltage
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      vm_r   <= membrane_voltage;
      drop_r <= spike_now && q_status.full;
    end
    if (cmd.prep) begin
      drive_r <= {{(MUL_B_W-DATA_W){cfg.reversal_potential[DATA_W-1]}},
                  cfg.reversal_potential}
               - {{(MUL_B_W-DATA_W){vm_r[DATA_W-1]}}, vm_r};
    end
  end

  // Trace updates: spike increment, then decayed value from the multiplier
  always_comb begin
    fall_nxt = fall_r;
    rise_nxt = rise_r;
    if (cmd.apply && q_status.fire) begin
      fall_nxt = trace_sat_add(fall_r, cfg.inverse_peak);
      rise_nxt = trace_sat_add(rise_r, cfg.inverse_peak);
    end
    if (cmd.store_fall) begin
      fall_nxt = prod_r[47:16];
    end
    if (cmd.store_rise) begin
      rise_nxt = prod_r[47:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fall_r <= '0;
      rise_r <= '0;
    end else begin
      fall_r <= fall_nxt;
      rise_r <= rise_nxt;
    end
  end

  // Trace difference, taken as the decayed rise trace lands
  always_ff @(posedge clk) begin
    if (cmd.store_rise) begin
      diff_r <= {1'b0, fall_r} - {1'b0, prod_r[47:16]};
    end
  end

  // Select multiplier operands
  always_comb begin
    case (cmd.mul_op)
      MUL_FALL: begin
        mul_a = {2'b00, fall_r};
        mul_b = {2'b00, cfg.fall_decay};
      end
      MUL_RISE: begin
        mul_a = {2'b00, rise_r};
        mul_b = {2'b00, cfg.rise_decay};
      end
      MUL_COND: begin
        mul_a = {diff_r[TRACE_W], diff_r};
        mul_b = {2'b00, cfg.peak_conductance};
      end
      MUL_CURR: begin
        mul_a = prod_r[49:16];  // conductance, floor of product over 2^16
        mul_b = drive_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Shared multiplier, registered product
  always_ff @(posedge clk) begin
    if (cmd.mul_op != MUL_NONE) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // Output register: load on finish, drop on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_cur_r  <= sat_current(prod_r);
      out_drop_r <= drop_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_synaptic_current = out_cur_r;
  assign out_spike_dropped    = out_drop_r;

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> out_free)
    else $error("output register overwritten");
`endif

endmodule

// ----- rtl/delayed_dual_exp_synapse_core.sv -----
// A tick runs from the input transfer through the registered read of the
// pending-spike queue front, the spike apply step and the single shared
// 34x18 multiplier, used four times per tick (fall decay, rise decay,
// conductance, current), to the result standing in the output register.
// No new tick is taken before that result is loaded, and a result waits
// while the previous one is still not taken. The output register lets a new
// tick enter while the previous result still waits. Spikes are held in a
// queue of PENDING_DEPTH due stamps; a spike that finds it full is dropped
// and flagged. Configuration registers are to be written through the cfg
// port only while the block is idle; the user must keep to this, as the
// block does not enforce it. Writes to unknown indexes are ignored.
// ----------------------------------------------------------------------------
// delayed_dual_exp_synapse_core
// Top level: configuration registers, controller, spike queue and datapath.
// ----------------------------------------------------------------------------
module delayed_dual_exp_synapse_core #(
  parameter int unsigned PENDING_DEPTH = dds_pkg::PENDING_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  dds_in_if.sink                              in_ch,
  dds_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [dds_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dds_pkg::DATA_W-1:0]          cfg_data
);
  import dds_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  cmd_t      cmd;
  q_status_t q_status;
  logic      in_ready;
  logic      out_free;
  logic      out_valid;
  logic signed [CUR_W-1:0] out_current;
  logic      out_dropped;

  // Decode configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_PEAK:       cfg_nxt.peak_conductance   = cfg_data;
        REG_REVERSAL:   cfg_nxt.reversal_potential = cfg_data;
        REG_FALL_DECAY: cfg_nxt.fall_decay         = cfg_data;
        REG_RISE_DECAY: cfg_nxt.rise_decay         = cfg_data;
        REG_INV_PEAK:   cfg_nxt.inverse_peak       = cfg_data;
        REG_DELAY:      cfg_nxt.delay_ticks        = cfg_data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.peak_conductance   <= PEAK_RST;
      cfg_r.reversal_potential <= REVERSAL_RST;
      cfg_r.fall_decay         <= FALL_RST;
      cfg_r.rise_decay         <= RISE_RST;
      cfg_r.inverse_peak       <= INV_PEAK_RST;
      cfg_r.delay_ticks        <= DELAY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .out_free (out_free),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  dds_queue #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .spike_now   (in_ch.spike_now),
    .delay_ticks (cfg_r.delay_ticks),
    .status      (q_status)
  );

  dds_datapath u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .cfg                  (cfg_r),
    .q_status             (q_status),
    .membrane_voltage     (in_ch.membrane_voltage),
    .spike_now            (in_ch.spike_now),
    .out_ready            (out_ch.ready),
    .out_valid            (out_valid),
    .out_synaptic_current (out_current),
    .out_spike_dropped    (out_dropped),
    .out_free             (out_free)
  );

  // Drive the channel ports
  assign in_ch.ready             = in_ready;
  assign out_ch.valid            = out_valid;
  assign out_ch.synaptic_current = out_current;
  assign out_ch.spike_dropped    = out_dropped;

endmodule
